// File: sv/assert_macros.svh
// Assertion helpers for the checker file pinv_chk.sv.
// Each macro expands to one labeled concurrent assertion on the rising clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pinv_pkg.sv
//------------------------------------------------------------------------------
// Permutation inverter package
// Request and status codes, field widths and the memory word layout.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package pinv_pkg;

    // Field widths.
    localparam int REQ_W  = 2;
    localparam int IMG_W  = 32;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 3;
    localparam int PRE_W  = 10;
    localparam int SIZE_W = 11;

    // Reset value of the map size register.
    localparam logic [SIZE_W-1:0] MAP_SIZE_RST = 11'd1024;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_SINGULAR  = 3'd2;
    localparam logic [STAT_W-1:0] ST_HALTED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_READY = 3'd4;
    localparam logic [STAT_W-1:0] ST_EXTRA     = 3'd5;

    // One word of the inverse table: taken mark and stored preimage.
    typedef struct packed {
        logic             taken;
        logic [PRE_W-1:0] pre;
    } t_entry;

endpackage

// File: sv/pinv_mem.sv
//------------------------------------------------------------------------------
// Permutation inverter table memory
// Single write port, single read port, read data registered.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pinv_mem
    import pinv_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: sv/pinv_ctrl.sv
//------------------------------------------------------------------------------
// Permutation inverter control
// Request sequencer: table read, check, write-back, result register and the
// clearing sweep of the table.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pinv_ctrl
    import pinv_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int AW          = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [IMG_W-1:0]  i_image,
    input  logic [IDX_W-1:0]  i_read_index,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic              busy,
    output logic [AW-1:0]     o_mem_raddr,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output t_entry            o_mem_wdata,
    input  t_entry            i_mem_rdata,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [PRE_W-1:0]  o_preimage,
    output logic              o_complete
);

    typedef enum logic [2:0] {
        S_CLR  = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [SIZE_W-1:0]  r_count, n_count;
    logic               r_err, n_err;
    logic [SIZE_W-1:0]  r_map_size;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [IMG_W-1:0]   r_image, n_image;
    logic [IDX_W-1:0]   r_ridx, n_ridx;
    logic               r_valid, n_valid;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [PRE_W-1:0]   r_pre, n_pre;
    logic               r_complete, n_complete;

    logic [SIZE_W-1:0]  size;
    logic [31:0]        ridx_ext;
    logic [AW-1:0]      img_addr;
    logic [AW-1:0]      ridx_addr;
    logic [AW-1:0]      rimg_addr;

    // Effective map size: zero acts as one, clamped to the table depth.
    always_comb begin
        if (r_map_size == '0) begin
            size = 11'd1;
        end else if (32'(r_map_size) > 32'(MAX_ENTRIES)) begin
            size = SIZE_W'(MAX_ENTRIES);
        end else begin
            size = r_map_size;
        end
    end

    // Table addresses taken from the incoming and the held request.
    assign ridx_ext  = 32'(i_read_index);
    assign img_addr  = i_image[AW-1:0];
    assign ridx_addr = ridx_ext[AW-1:0];
    assign rimg_addr = r_image[AW-1:0];

    // Sequencer and result computation.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_err       = r_err;
        n_req       = r_req;
        n_image     = r_image;
        n_ridx      = r_ridx;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_pre       = r_pre;
        n_complete  = r_complete;
        o_mem_raddr = img_addr;
        o_mem_we    = 1'b0;
        o_mem_waddr = rimg_addr;
        o_mem_wdata = '0;

        unique case (r_state)
            S_CLR: begin
                // Sweep the whole table back to not-taken.
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_addr;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_type == REQ_READ) begin
                    o_mem_raddr = ridx_addr;
                end
                if (start) begin
                    n_req   = i_req_type;
                    n_image = i_image;
                    n_ridx  = i_read_index;
                    case (i_req_type) inside
                        REQ_LOAD, REQ_READ: begin
                            n_state = S_EXEC;
                        end
                        REQ_CLEAR: begin
                            n_count    = '0;
                            n_err      = 1'b0;
                            n_clr_addr = '0;
                            n_state    = S_CLR;
                            n_valid    = 1'b1;
                            n_status   = ST_OK;
                            n_pre      = '0;
                            n_complete = 1'b0;
                        end
                        default: begin
                            // Unused code: answered without any change.
                            n_valid    = 1'b1;
                            n_status   = ST_OK;
                            n_pre      = '0;
                            n_complete = !r_err && (r_count >= size);
                        end
                    endcase
                end
            end
            S_EXEC: begin
                // Table word is now on the read port: check and write back.
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_pre    = '0;
                if (r_req == REQ_LOAD) begin
                    if (r_err) begin
                        n_status = ST_HALTED;
                    end else if (r_count >= size) begin
                        n_status = ST_EXTRA;
                    end else if (r_image >= 32'(size)) begin
                        n_status = ST_RANGE;
                        n_err    = 1'b1;
                    end else if (i_mem_rdata.taken) begin
                        n_status = ST_SINGULAR;
                        n_err    = 1'b1;
                    end else begin
                        o_mem_we          = 1'b1;
                        o_mem_waddr       = rimg_addr;
                        o_mem_wdata.taken = 1'b1;
                        o_mem_wdata.pre   = r_count[PRE_W-1:0];
                        n_count           = SIZE_W'(r_count + 11'd1);
                    end
                end else begin
                    if (r_err) begin
                        n_status = ST_HALTED;
                    end else if (r_count < size) begin
                        n_status = ST_NOT_READY;
                    end else if ({1'b0, r_ridx} >= size) begin
                        n_status = ST_RANGE;
                    end else if (!i_mem_rdata.taken) begin
                        n_status = ST_NOT_READY;
                    end else begin
                        n_pre = i_mem_rdata.pre;
                    end
                end
                n_complete = !n_err && (n_count >= size);
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_err      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_err      <= n_err;
            r_valid    <= n_valid;
        end
    end

    // Map size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size <= MAP_SIZE_RST;
        end else if (i_cfg_we) begin
            r_map_size <= i_cfg_wdata;
        end
    end

    // Held request and result payload.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_image    <= n_image;
        r_ridx     <= n_ridx;
        r_status   <= n_status;
        r_pre      <= n_pre;
        r_complete <= n_complete;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_preimage = r_pre;
    assign o_complete = r_complete;

endmodule

// File: sv/permutation_inverter_top.sv
//------------------------------------------------------------------------------
// Permutation inverter
// Builds the inverse of a map loaded entry by entry and answers read-back.
//------------------------------------------------------------------------------
// Channel   Direction  Handshake                Fields
// request   in         start & !busy            i_req_type, i_image, i_read_index
// result    out        o_valid (one cycle)      o_status, o_preimage, o_complete
// config    in         i_cfg_we                 i_cfg_wdata (map size)
//
// Load and read items take one table read, then check and
// write-back; the result appears in the cycle after that.
// Clear and unused request items answer in the next cycle; a clear then
// sweeps the whole table with busy high.
// After reset the same sweep runs before the first item.
// Results cannot be stalled; each is shown for exactly one cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_inverter_top
    import pinv_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [IMG_W-1:0]  i_image,
    input  logic [IDX_W-1:0]  i_read_index,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [PRE_W-1:0]  o_preimage,
    output logic              o_complete
);

    localparam int AW = $clog2(MAX_ENTRIES);

    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    // Request sequencer.
    pinv_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req_type   (i_req_type),
        .i_image      (i_image),
        .i_read_index (i_read_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .busy         (busy),
        .o_mem_raddr  (mem_raddr),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .i_mem_rdata  (mem_rdata),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_preimage   (o_preimage),
        .o_complete   (o_complete)
    );

    // Inverse table with taken marks.
    pinv_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// File: sv/pinv_chk.sv
//------------------------------------------------------------------------------
// Permutation inverter checker
// Port-level assertions on item timing and result consistency.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pinv_chk
    import pinv_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [REQ_W-1:0]  i_req_type,
    input logic              o_valid,
    input logic [STAT_W-1:0] o_status,
    input logic [PRE_W-1:0]  o_preimage,
    input logic              o_complete
);

    // Reset starts the table sweep, so the block reports busy.
    `ASSERT_CLK_ALWAYS(a_busy_after_rst, i_clk, !i_rst_n |=> busy, "not busy after reset")

    // Load and read items answer after the table read and the check state.
    `ASSERT_CLK(a_lookup_latency, i_clk, i_rst_n, (start && !busy && (i_req_type == REQ_LOAD || i_req_type == REQ_READ)) |=> ##1 o_valid, "lookup result missing")

    // Clear and unused items answer in the next cycle.
    `ASSERT_CLK(a_short_latency, i_clk, i_rst_n, (start && !busy && (i_req_type != REQ_LOAD && i_req_type != REQ_READ)) |=> o_valid, "short result missing")

    // Any failing status carries a zero preimage.
    `ASSERT_CLK(a_pre_zero, i_clk, i_rst_n, (o_valid && o_status != ST_OK) |-> (o_preimage == '0), "preimage on failed item")

    // A halted map is never complete.
    `ASSERT_CLK(a_halt_incomplete, i_clk, i_rst_n, (o_valid && o_status == ST_HALTED) |-> !o_complete, "complete while halted")

endmodule

bind permutation_inverter_top pinv_chk u_pinv_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req_type (i_req_type),
    .o_valid    (o_valid),
    .o_status   (o_status),
    .o_preimage (o_preimage),
    .o_complete (o_complete)
);
